// File: rtl/core/sdcr_pkg.sv
`default_nettype none
package sdcr_pkg;

   // Kind codes of an input word
   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_READING  = 1'b1;

   // Kind codes of a report word
   localparam logic REPORT_TEMP  = 1'b0;
   localparam logic REPORT_HUMID = 1'b1;

   // Register indexes on the CSR port (byte address = 4 * index)
   localparam logic CSR_TEMP_DB  = 1'b0;
   localparam logic CSR_HUMID_DB = 1'b1;

   localparam logic [7:0] TEMP_DB_RESET  = 8'd2;
   localparam logic [7:0] HUMID_DB_RESET = 8'd3;

   // One channel table entry
   typedef struct packed {
      logic [7:0]         pin;
      logic               force_rpt;
      logic signed [11:0] temp;
      logic [9:0]         humid;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_SEND_T,
      ST_SEND_H
   } ctl_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;
      logic rd_en;
      logic inc_idx;
      logic wr_new;
      logic wr_force;
      logic wr_update;
      logic load_t;
      logic load_h;
   } ctl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic kind;
      logic read_ok;
      logic idx_at_end;
      logic full;
      logic pin_match;
      logic emit_t;
      logic emit_h;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/core/sdcr_req_if.sv
`default_nettype none
interface sdcr_req_if;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [7:0]        pin;
   logic              read_ok;
   logic signed [11:0] temperature;
   logic [9:0]        humidity;

   modport source (output valid, kind, pin, read_ok, temperature, humidity, input ready);
   modport sink   (input valid, kind, pin, read_ok, temperature, humidity, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sdcr_rsp_if.sv
`default_nettype none
interface sdcr_rsp_if;
   logic              valid;
   logic              ready;
   logic              report_kind;
   logic [7:0]        report_pin;
   logic signed [11:0] report_value;
   logic              last;

   modport source (output valid, report_kind, report_pin, report_value, last, input ready);
   modport sink   (input valid, report_kind, report_pin, report_value, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sensor_deadband_change_reporter.sv
`default_nettype none
// Channel  Dir  Handshake           Carries
// req_chan in   valid/ready         kind, pin, read_ok, temperature, humidity
// rsp_chan out  valid/ready         report_kind, report_pin, report_value, last
// csr_*    in   APB, pready tied 1  temp_deadband @0x0, humid_deadband @0x4
//
// An item is accepted in ST_IDLE, then each table entry is compared by a read in
// ST_LOOKUP and a check in ST_CHECK; a pin not found ends with a final ST_LOOKUP.
// A good reading of a known pin then passes ST_SEND_T and ST_SEND_H to queue its words.
// Synchronous reset clears the fill count and sets the deadbands to 2 and 3.
// A stalled rsp_chan holds one word in the output register; queueing the next word
// waits for it to drain, and the following item is taken in once the last word is loaded.
module sensor_deadband_change_reporter #(
   parameter int SLOTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   sdcr_req_if.sink          req_chan,
   sdcr_rsp_if.source        rsp_chan,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   sdcr_pkg::ctl_cmd_type    cmd;
   sdcr_pkg::dp_status_type  sts;
   logic                     csr_wr;
   logic [7:0]               csr_rd_byte;

   // register write lands at the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {24'b0, csr_rd_byte};

   sdcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdcr_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_chan.kind),
      .req_pin          (req_chan.pin),
      .req_read_ok      (req_chan.read_ok),
      .req_temperature  (req_chan.temperature),
      .req_humidity     (req_chan.humidity),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_report_kind  (rsp_chan.report_kind),
      .rsp_report_pin   (rsp_chan.report_pin),
      .rsp_report_value (rsp_chan.report_value),
      .rsp_last         (rsp_chan.last),
      .csr_wr           (csr_wr),
      .csr_sel          (csr_paddr[2]),
      .csr_wdata        (csr_pwdata[7:0]),
      .csr_rd_data      (csr_rd_byte),
      .cmd              (cmd),
      .sts              (sts)
   );
endmodule
`default_nettype wire

// File: rtl/core/sdcr_ram.sv
`default_nettype none
module sdcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/core/sdcr_ctrl.sv
`default_nettype none
module sdcr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sdcr_pkg::dp_status_type sts,
   output sdcr_pkg::ctl_cmd_type       cmd
);
   sdcr_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdcr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sdcr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sdcr_pkg::ST_LOOKUP;
            end
         end
         sdcr_pkg::ST_LOOKUP: begin
            if (sts.idx_at_end) begin
               // pin not in table
               if (sts.kind == sdcr_pkg::KIND_REGISTER && !sts.full) begin
                  cmd.wr_new = 1'b1;
               end
               state_in = sdcr_pkg::ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = sdcr_pkg::ST_CHECK;
            end
         end
         sdcr_pkg::ST_CHECK: begin
            if (sts.pin_match) begin
               if (sts.kind == sdcr_pkg::KIND_REGISTER) begin
                  cmd.wr_force = 1'b1;
                  state_in     = sdcr_pkg::ST_IDLE;
               end else if (sts.read_ok) begin
                  cmd.wr_update = 1'b1;
                  state_in      = sdcr_pkg::ST_SEND_T;
               end else begin
                  state_in = sdcr_pkg::ST_IDLE;
               end
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = sdcr_pkg::ST_LOOKUP;
            end
         end
         sdcr_pkg::ST_SEND_T: begin
            if (!sts.emit_t) begin
               state_in = sdcr_pkg::ST_SEND_H;
            end else if (sts.out_free) begin
               cmd.load_t = 1'b1;
               state_in   = sdcr_pkg::ST_SEND_H;
            end
         end
         sdcr_pkg::ST_SEND_H: begin
            if (!sts.emit_h) begin
               state_in = sdcr_pkg::ST_IDLE;
            end else if (sts.out_free) begin
               cmd.load_h = 1'b1;
               state_in   = sdcr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdcr_pkg::ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/sdcr_datapath.sv
`default_nettype none
module sdcr_datapath #(
   parameter int SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input word
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_pin,
   input  wire logic                  req_read_ok,
   input  wire logic signed [11:0]    req_temperature,
   input  wire logic [9:0]            req_humidity,
   // report word
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_report_kind,
   output logic [7:0]                 rsp_report_pin,
   output logic signed [11:0]         rsp_report_value,
   output logic                       rsp_last,
   // CSR
   input  wire logic                  csr_wr,
   input  wire logic                  csr_sel,
   input  wire logic [7:0]            csr_wdata,
   output logic [7:0]                 csr_rd_data,
   // control
   input  wire sdcr_pkg::ctl_cmd_type cmd,
   output sdcr_pkg::dp_status_type    sts
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = $bits(sdcr_pkg::entry_type);

   // deadband registers
   logic [7:0] temp_db_ff, humid_db_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_db_ff  <= sdcr_pkg::TEMP_DB_RESET;
         humid_db_ff <= sdcr_pkg::HUMID_DB_RESET;
      end else if (csr_wr) begin
         if (csr_sel == sdcr_pkg::CSR_TEMP_DB) begin
            temp_db_ff <= csr_wdata;
         end else begin
            humid_db_ff <= csr_wdata;
         end
      end
   end

   // held input word
   logic              kind_ff, read_ok_ff;
   logic [7:0]        pin_ff;
   logic signed [11:0] temp_ff;
   logic [9:0]        humid_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         pin_ff     <= req_pin;
         read_ok_ff <= req_read_ok;
         temp_ff    <= req_temperature;
         humid_ff   <= req_humidity;
      end
   end

   // scan index and fill count
   logic [CW-1:0] idx_ff, count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.wr_new) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.capture) begin
            idx_ff <= '0;
         end else if (cmd.inc_idx) begin
            idx_ff <= idx_ff + CW'(1);
         end
      end
   end

   // entry table
   sdcr_pkg::entry_type ent, wr_ent;
   logic [EW-1:0]       rd_word;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;

   assign ent = sdcr_pkg::entry_type'(rd_word);

   // compare against cached values
   logic signed [12:0] dt;
   logic [12:0]        dt_neg;
   logic [11:0]        adt;
   logic [10:0]        dh;
   logic [10:0]        dh_neg;
   logic [9:0]         adh;
   logic               emit_t_calc, emit_h_calc;

   always_comb begin
      dt     = {temp_ff[11], temp_ff} - {ent.temp[11], ent.temp};
      dt_neg = -dt;
      adt    = dt[12] ? dt_neg[11:0] : dt[11:0];
      dh     = {1'b0, humid_ff} - {1'b0, ent.humid};
      dh_neg = -dh;
      adh    = dh[10] ? dh_neg[9:0] : dh[9:0];
      emit_t_calc = ent.force_rpt || (adt > {4'b0, temp_db_ff});
      emit_h_calc = ent.force_rpt || (adh > {2'b0, humid_db_ff});
   end

   always_comb begin
      wr_ent  = ent;
      wr_addr = idx_ff[AW-1:0];
      wr_en   = cmd.wr_new || cmd.wr_force || cmd.wr_update;
      if (cmd.wr_new) begin
         wr_ent.pin       = pin_ff;
         wr_ent.force_rpt = 1'b0;
         wr_ent.temp      = '0;
         wr_ent.humid     = '0;
         wr_addr          = count_ff[AW-1:0];
      end else if (cmd.wr_force) begin
         wr_ent.force_rpt = 1'b1;
      end else begin
         wr_ent.force_rpt = 1'b0;
         if (emit_t_calc) begin
            wr_ent.temp = temp_ff;
         end
         if (emit_h_calc) begin
            wr_ent.humid = humid_ff;
         end
      end
   end

   sdcr_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   // which reports the current reading owes
   logic emit_t_ff, emit_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_t_ff <= 1'b0;
         emit_h_ff <= 1'b0;
      end else if (cmd.wr_update) begin
         emit_t_ff <= emit_t_calc;
         emit_h_ff <= emit_h_calc;
      end
   end

   // output register
   logic              out_valid_ff;
   logic              out_kind_ff, out_last_ff;
   logic [7:0]        out_pin_ff;
   logic signed [11:0] out_value_ff;
   logic              out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_t || cmd.load_h) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_t) begin
         out_kind_ff  <= sdcr_pkg::REPORT_TEMP;
         out_pin_ff   <= pin_ff;
         out_value_ff <= temp_ff;
         out_last_ff  <= !emit_h_ff;
      end else if (cmd.load_h) begin
         out_kind_ff  <= sdcr_pkg::REPORT_HUMID;
         out_pin_ff   <= pin_ff;
         out_value_ff <= {2'b0, humid_ff};
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_report_kind  = out_kind_ff;
   assign rsp_report_pin   = out_pin_ff;
   assign rsp_report_value = out_value_ff;
   assign rsp_last         = out_last_ff;

   assign csr_rd_data = (csr_sel == sdcr_pkg::CSR_TEMP_DB) ? temp_db_ff : humid_db_ff;

   always_comb begin
      sts.kind       = kind_ff;
      sts.read_ok    = read_ok_ff;
      sts.idx_at_end = (idx_ff == count_ff);
      sts.full       = (count_ff == CW'(SLOTS));
      sts.pin_match  = (ent.pin == pin_ff);
      sts.emit_t     = emit_t_ff;
      sts.emit_h     = emit_h_ff;
      sts.out_free   = out_free;
   end
endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS         = 16;
   // Worst-case table scan plus output queueing, with margin.
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 800000;

   typedef struct packed {
      logic               kind;
      logic [7:0]         pin;
      logic signed [11:0] value;
      logic               last;
   } report_word_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sdcr_req_if req_chan();
   sdcr_rsp_if rsp_chan();

   sensor_deadband_change_reporter #(.SLOTS(SLOTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Channel table as the block should hold it
   int unsigned        fill_count = 0;
   logic [7:0]         chan_pin   [SLOTS];
   logic               chan_force [SLOTS];
   logic signed [11:0] chan_temp  [SLOTS];
   logic [9:0]         chan_humid [SLOTS];
   logic [7:0]         temp_band  = sdcr_pkg::TEMP_DB_RESET;
   logic [7:0]         humid_band = sdcr_pkg::HUMID_DB_RESET;

   report_word_type pending_reports[$];
   int unsigned  report_errors = 0;
   int unsigned  cycle_count   = 0;
   logic         steady        = 1'b0;   // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int lookup_pin(input logic [7:0] pin);
      for (int i = 0; i < fill_count; i++)
         if (chan_pin[i] == pin) return i;
      return -1;
   endfunction

   function automatic logic [7:0] unused_pin();
      logic [7:0] pin;
      do pin = 8'($urandom_range(0, 255)); while (lookup_pin(pin) >= 0);
      return pin;
   endfunction

   // Table update and the reports one accepted word should cause
   function automatic void update_channels(input logic kind, input logic [7:0] pin,
                                           input logic ok, input logic signed [11:0] temp,
                                           input logic [9:0] humid);
      int              slot;
      int              dt;
      int              dh;
      logic            send_t;
      logic            send_h;
      report_word_type rpt;
      slot = lookup_pin(pin);
      if (kind == sdcr_pkg::KIND_REGISTER) begin
         if (slot >= 0) begin
            chan_force[slot] = 1'b1;
         end else if (fill_count < SLOTS) begin
            chan_pin[fill_count]   = pin;
            chan_force[fill_count] = 1'b0;
            chan_temp[fill_count]  = '0;
            chan_humid[fill_count] = '0;
            fill_count++;
         end
         return;
      end
      if (slot < 0 || !ok) return;
      dt = int'(temp) - int'(chan_temp[slot]);
      dh = int'(humid) - int'(chan_humid[slot]);
      if (dt < 0) dt = -dt;
      if (dh < 0) dh = -dh;
      send_t = chan_force[slot] || (dt > int'(temp_band));
      send_h = chan_force[slot] || (dh > int'(humid_band));
      if (send_t) begin
         rpt.kind  = sdcr_pkg::REPORT_TEMP;
         rpt.pin   = pin;
         rpt.value = temp;
         rpt.last  = !send_h;
         pending_reports.push_back(rpt);
         chan_temp[slot] = temp;
      end
      if (send_h) begin
         rpt.kind  = sdcr_pkg::REPORT_HUMID;
         rpt.pin   = pin;
         rpt.value = {2'b00, humid};
         rpt.last  = 1'b1;
         pending_reports.push_back(rpt);
         chan_humid[slot] = humid;
      end
      chan_force[slot] = 1'b0;
   endfunction

   // Mostly near the cached value so both sides of the deadband get hit
   function automatic logic signed [11:0] temp_near(input int slot);
      int span;
      span = int'(temp_band) + 2;
      if ($urandom_range(0, 3) == 0) return 12'($urandom());
      return 12'(int'(chan_temp[slot]) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [9:0] humid_near(input int slot);
      int span;
      span = int'(humid_band) + 2;
      if ($urandom_range(0, 3) == 0) return 10'($urandom());
      return 10'(int'(chan_humid[slot]) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // valid is left high after acceptance; it drops only when a gap follows or drain_reports holds off the sender
   task automatic send_word(input logic kind, input logic [7:0] pin, input logic ok,
                            input logic signed [11:0] temp, input logic [9:0] humid);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= kind;
      req_chan.pin         <= pin;
      req_chan.read_ok     <= ok;
      req_chan.temperature <= temp;
      req_chan.humidity    <= humid;
      do @(posedge clock); while (!req_chan.ready);
      update_channels(kind, pin, ok, temp, humid);
   endtask

   // Hold off the sender until every report is in, then let a silent item finish
   task automatic drain_reports();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer, with psel and penable dropped afterwards
   task automatic csr_access(input logic write, input logic idx, input logic [7:0] value,
                             output logic [7:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata[7:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic idx, input logic [7:0] want);
      logic [7:0] got;
      csr_access(1'b0, idx, 8'h00, got);
      if (got !== want) begin
         if (report_errors < 10)
            $display("csr readback mismatch: reg %0d expected %0d got %0d", idx, want, got);
         report_errors++;
      end
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] value);
      logic [7:0] unused;
      csr_access(1'b1, idx, value, unused);
      if (idx == sdcr_pkg::CSR_TEMP_DB) temp_band = value;
      else humid_band = value;
      csr_read_check(idx, value);
   endtask

   // Report checker: every accepted word against the oldest expectation
   always @(posedge clock) begin : check_reports
      report_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_reports.size() == 0) begin
            if (report_errors < 10)
               $display("unexpected report word: kind %0d pin %0d value %0d last %0d",
                        rsp_chan.report_kind, rsp_chan.report_pin,
                        rsp_chan.report_value, rsp_chan.last);
            report_errors++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_chan.report_kind !== want.kind || rsp_chan.report_pin !== want.pin ||
                rsp_chan.report_value !== want.value || rsp_chan.last !== want.last) begin
               if (report_errors < 10)
                  $display("report mismatch: expected kind %0d pin %0d value %0d last %0d, %s",
                           want.kind, want.pin, want.value, want.last, "got below");
               if (report_errors < 10)
                  $display("   got kind %0d pin %0d value %0d last %0d",
                           rsp_chan.report_kind, rsp_chan.report_pin,
                           rsp_chan.report_value, rsp_chan.last);
               report_errors++;
            end
         end
      end
   end

   // Report sink with a random stall before each word while steady is clear
   initial begin : report_sink
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic test_reset_deadbands();
      csr_read_check(sdcr_pkg::CSR_TEMP_DB, sdcr_pkg::TEMP_DB_RESET);
      csr_read_check(sdcr_pkg::CSR_HUMID_DB, sdcr_pkg::HUMID_DB_RESET);
   endtask

   // Deadbands at reset values: 2 tenths temp, 3 tenths humidity
   task automatic test_directed_cases();
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, 12'sd50, 10'd50); // unknown pin
      send_word(sdcr_pkg::KIND_REGISTER, 8'h00, 1'b0, 12'sd0, 10'd0);
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, 12'sd2, 10'd3); // on the band edge
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, 12'sd3, 10'd4); // just over: both
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, -12'sd400, 10'd4); // temp only
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, -12'sd400, 10'd1000); // humidity only
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b0, 12'sd1250, 10'd0); // failed read
      send_word(sdcr_pkg::KIND_REGISTER, 8'hFF, 1'b1, 12'sh5A5, 10'h2AA);
      send_word(sdcr_pkg::KIND_REGISTER, 8'h00, 1'b1, 12'sh5A5, 10'h2AA); // repeat: force
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b0, -12'sd400, 10'd1000); // force survives
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, -12'sd400, 10'd1000); // forced: both
      send_word(sdcr_pkg::KIND_READING, 8'h00, 1'b1, -12'sd400, 10'd1000); // force cleared
      send_word(sdcr_pkg::KIND_READING, 8'hFF, 1'b1, 12'sh7FF, 10'h3FF); // out of range
      send_word(sdcr_pkg::KIND_READING, 8'hFF, 1'b1, 12'sh800, 10'h000); // widest swing
      send_word(sdcr_pkg::KIND_REGISTER, 8'hFF, 1'b0, 12'sh7FF, 10'h3FF);
      send_word(sdcr_pkg::KIND_READING, 8'hFF, 1'b1, 12'sh800, 10'h000); // forced, unchanged
      send_word(sdcr_pkg::KIND_REGISTER, 8'h55, 1'b0, 12'sd0, 10'd0);
      send_word(sdcr_pkg::KIND_REGISTER, 8'hAA, 1'b1, 12'sd0, 10'd0);
      send_word(sdcr_pkg::KIND_READING, 8'h55, 1'b1, 12'sd0, 10'd0);
      send_word(sdcr_pkg::KIND_READING, 8'hAA, 1'b1, -12'sd3, 10'd0);
   endtask

   task automatic test_full_table();
      logic [7:0] pin;
      while (fill_count < SLOTS)
         send_word(sdcr_pkg::KIND_REGISTER, unused_pin(), 1'($urandom()), 12'($urandom()),
                   10'($urandom()));
      pin = unused_pin();
      send_word(sdcr_pkg::KIND_REGISTER, pin, 1'b1, 12'sd0, 10'd0); // dropped
      send_word(sdcr_pkg::KIND_READING, pin, 1'b1, 12'sd900, 10'd900); // still unknown
      send_word(sdcr_pkg::KIND_REGISTER, chan_pin[SLOTS - 1], 1'b0, 12'sd0, 10'd0);
      send_word(sdcr_pkg::KIND_READING, chan_pin[SLOTS - 1], 1'b1, 12'sd0, 10'd0);
   endtask

   // Table is full from here on; ignored words do not count toward the target
   task automatic test_random_traffic(input int unsigned target);
      int unsigned counted;
      int unsigned sent;
      int unsigned pick;
      int          slot;
      counted = 0;
      sent    = 0;
      while (counted < target) begin
         if (sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         sent++;
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, fill_count - 1);
         if (pick < 70) begin
            send_word(sdcr_pkg::KIND_READING, chan_pin[slot], 1'b1, temp_near(slot),
                      humid_near(slot));
            counted++;
         end else if (pick < 78) begin
            send_word(sdcr_pkg::KIND_READING, chan_pin[slot], 1'b0, temp_near(slot),
                      humid_near(slot));
         end else if (pick < 86) begin
            send_word(sdcr_pkg::KIND_REGISTER, chan_pin[slot], 1'($urandom()),
                      12'($urandom()), 10'($urandom()));
            counted++;
         end else if (pick < 93) begin
            send_word(sdcr_pkg::KIND_READING, unused_pin(), 1'($urandom()),
                      12'($urandom()), 10'($urandom()));
         end else begin
            send_word(sdcr_pkg::KIND_REGISTER, unused_pin(), 1'($urandom()),
                      12'($urandom()), 10'($urandom()));
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_deadband_phase(input logic [7:0] t_band, input logic [7:0] h_band,
                                      input int unsigned target);
      drain_reports();
      csr_write(sdcr_pkg::CSR_TEMP_DB, t_band);
      csr_write(sdcr_pkg::CSR_HUMID_DB, h_band);
      test_random_traffic(target);
   endtask

   initial begin
      reset                <= 1'b1;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= sdcr_pkg::KIND_REGISTER;
      req_chan.pin         <= '0;
      req_chan.read_ok     <= 1'b0;
      req_chan.temperature <= '0;
      req_chan.humidity    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_deadbands();
      test_directed_cases();
      test_full_table();
      test_random_traffic(210);
      test_deadband_phase(8'd0, 8'd0, 210);
      test_deadband_phase(8'd255, 8'd255, 210);
      test_deadband_phase(8'd0, 8'd255, 210);
      test_deadband_phase(8'd255, 8'd0, 210);
      test_deadband_phase(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)), 210);

      drain_reports();
      if (report_errors == 0 && pending_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
